// ===== rtl/alid_pkg.sv =====
// Package for the array list core: shared widths, operation and status codes,
// sequencer states and the compare result bundle.
// No dependencies.
package alid_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STAT_W    = 2;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried by kind
  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_DELETE = 3'd2,
    K_LINEAR = 3'd3,
    K_MTF    = 3'd4,
    K_BINARY = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_DEL_FIRST,
    ST_SHIFT_DN,
    ST_SCAN,
    ST_SWAP,
    ST_BIN_RD
  } state_e;

  // outcome of the shared comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== rtl/alid_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module alid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/alid_cmp.sv =====
// Shared comparator: key against the word just read from the store.
// Depends on alid_pkg.
module alid_cmp
  import alid_pkg::*;
(
  input  logic signed [DATA_W-1:0] key_i,
  input  logic signed [DATA_W-1:0] data_i,
  output cmp_res_t                 cmp_o
);

  // equality for all searches, signed order for the halving walk
  always_comb begin
    cmp_o.eq = (key_i == data_i);
    cmp_o.lt = (key_i < data_i);
  end

endmodule

// ===== rtl/array_list_insert_delete_search_core.sv =====
// Array list core: packed list of signed 32-bit words with append, insert,
// delete, linear search, move-to-front search and binary search.
// Channels: an item (kind_i, index_i, value_i) is taken when start is high and
// busy is low. Its single result (status_o, position_o, removed_value_o,
// fill_count_o) is shown for exactly one cycle with done_o high; the receiver
// cannot hold it off. The capacity register is written through cfg_valid_i /
// cfg_data_i, always ready, and should only be written while busy is low.
// Append, an unknown kind and any failed check finish straight from idle. Insert
// fetches the last entry and moves entries up one place down to the index, then
// writes the new word (at once when the index equals the fill). Delete reads the
// removed word, then moves each later entry down. Linear search scans from the
// head to a hit or the end; move-to-front then swaps the hit with the head.
// Binary search alternates a probe issue and a compare, halving the range.
// One item is worked on at a time; all store reads go through the single
// registered read port, and searches check each word with the shared compare.
// Reset clears the fill count to 0, sets capacity to 16 and idles the sequencer;
// store contents stay undefined and are never read before being written.
module array_list_insert_delete_search_core
  import alid_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic [IDX_W-1:0]         index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [IDX_W-1:0]         position_o,
  output logic signed [DATA_W-1:0] removed_value_o,
  output logic [CNT_W-1:0]         fill_count_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] cap_q;
  logic             done_q, done_d;

  // working registers
  logic [PW-1:0]            ptr_q, ptr_d;
  logic [PW-1:0]            lo_q, lo_d;
  logic [PW-1:0]            hi_q, hi_d;
  kind_e                    kind_q, kind_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] first_q, first_d;
  status_e                  status_q, status_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic signed [DATA_W-1:0] rem_q, rem_d;

  // store and comparator connections
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  cmp_res_t          cmp;

  // widened views and pointer arithmetic
  logic [PW-1:0] used_x, cap_x, idx_in_x, idx_qx;
  logic [PW-1:0] used_m1, ptr_p1, ptr_p2, ptr_m1, mid_sum, mid;
  logic          full;

  assign used_x   = {{(PW-CNT_W){1'b0}}, used_q};
  assign cap_x    = {{(PW-CNT_W){1'b0}}, cap_q};
  assign idx_in_x = {{(PW-IDX_W){1'b0}}, index_i};
  assign idx_qx   = {{(PW-IDX_W){1'b0}}, idx_q};
  assign used_m1  = used_x - PW'(1);
  assign ptr_p1   = ptr_q + PW'(1);
  assign ptr_p2   = ptr_q + PW'(2);
  assign ptr_m1   = ptr_q - PW'(1);
  assign mid_sum  = lo_q + hi_q - PW'(1);
  assign mid      = mid_sum >> 1;
  assign full     = (used_x >= cap_x) || (used_x >= DEPTH_P);

  alid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  alid_cmp u_cmp (
    .key_i  (key_q),
    .data_i (ram_rdata),
    .cmp_o  (cmp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    kind_q   <= kind_d;
    idx_q    <= idx_d;
    key_q    <= key_d;
    first_q  <= first_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    rem_q    <= rem_d;
  end

  // sequencer: next state, store access and result capture
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    done_d    = 1'b0;
    ptr_d     = ptr_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    key_d     = key_q;
    first_d   = first_q;
    status_d  = status_q;
    pos_d     = pos_q;
    rem_d     = rem_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d   = kind_e'(kind_i);
          idx_d    = index_i;
          key_d    = value_i;
          status_d = STAT_OK;
          pos_d    = '0;
          rem_d    = '0;
          case (kind_e'(kind_i))
            K_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = used_x[AW-1:0];
                ram_wdata = value_i;
                used_d    = used_q + CNT_W'(1);
              end
            end
            K_INSERT: begin
              if (idx_in_x > used_x) begin
                status_d = STAT_RANGE;
                done_d   = 1'b1;
              end else if (full) begin
                status_d = STAT_FULL;
                done_d   = 1'b1;
              end else if (idx_in_x == used_x) begin
                ram_we    = 1'b1;
                ram_waddr = used_x[AW-1:0];
                ram_wdata = value_i;
                used_d    = used_q + CNT_W'(1);
                done_d    = 1'b1;
              end else begin
                // fetch the last entry, then walk down moving entries up
                ram_raddr = used_m1[AW-1:0];
                ptr_d     = used_m1;
                state_d   = ST_SHIFT_UP;
              end
            end
            K_DELETE: begin
              if (idx_in_x >= used_x) begin
                status_d = STAT_RANGE;
                done_d   = 1'b1;
              end else begin
                ram_raddr = idx_in_x[AW-1:0];
                ptr_d     = idx_in_x;
                state_d   = ST_DEL_FIRST;
              end
            end
            K_LINEAR, K_MTF: begin
              if (used_q == '0) begin
                status_d = STAT_MISS;
                done_d   = 1'b1;
              end else begin
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            K_BINARY: begin
              if (used_q == '0) begin
                status_d = STAT_MISS;
                done_d   = 1'b1;
              end else begin
                lo_d    = '0;
                hi_d    = used_x;
                state_d = ST_BIN_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // entry at ptr arrives: move it one place up, fetch the one below
      ST_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_p1[AW-1:0];
        ram_wdata = ram_rdata;
        if (ptr_q == idx_qx) begin
          state_d = ST_INS_WR;
        end else begin
          ram_raddr = ptr_m1[AW-1:0];
          ptr_d     = ptr_m1;
        end
      end

      // drop the new word into the gap
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_qx[AW-1:0];
        ram_wdata = key_q;
        used_d    = used_q + CNT_W'(1);
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end

      // removed word arrives
      ST_DEL_FIRST: begin
        rem_d = ram_rdata;
        if (ptr_p1 == used_x) begin
          used_d  = used_q - CNT_W'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_raddr = ptr_p1[AW-1:0];
          state_d   = ST_SHIFT_DN;
        end
      end

      // entry at ptr+1 arrives: move it down to ptr
      ST_SHIFT_DN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (ptr_p2 == used_x) begin
          used_d  = used_q - CNT_W'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_raddr = ptr_p2[AW-1:0];
          ptr_d     = ptr_p1;
        end
      end

      // one entry per cycle through the comparator
      ST_SCAN: begin
        if (ptr_q == '0) begin
          first_d = ram_rdata;
        end
        if (cmp.eq) begin
          pos_d = ptr_q[IDX_W-1:0];
          if ((kind_q == K_MTF) && (ptr_q != '0)) begin
            // old head goes to the hit slot, the key to the head next cycle
            ram_we    = 1'b1;
            ram_waddr = ptr_q[AW-1:0];
            ram_wdata = first_q;
            state_d   = ST_SWAP;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (ptr_p1 == used_x) begin
          status_d = STAT_MISS;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          ram_raddr = ptr_p1[AW-1:0];
          ptr_d     = ptr_p1;
        end
      end

      ST_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end

      // halving walk, hi is one past the upper bound; probe issue or compare
      ST_BIN_RD: begin
        if (ptr_q[PW-1] == 1'b0 && lo_q < hi_q && kind_q == K_BINARY && !first_q[0]) begin
          ram_raddr = mid[AW-1:0];
          ptr_d     = mid;
          first_d   = {DATA_W{1'b1}};
        end else if (first_q[0]) begin
          // probe data has arrived
          first_d = '0;
          if (cmp.eq) begin
            pos_d   = ptr_q[IDX_W-1:0];
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (cmp.lt) begin
            hi_d = ptr_q;
          end else begin
            lo_d = ptr_p1;
          end
        end else begin
          status_d = STAT_MISS;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // binary walk starts in issue phase
    if (state_q == ST_IDLE && start && kind_e'(kind_i) == K_BINARY) begin
      first_d = '0;
      ptr_d   = '0;
    end
  end

  // outputs
  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign position_o      = pos_q;
  assign removed_value_o = rem_q;
  assign fill_count_o    = used_q;
  assign cfg_ready_o     = 1'b1;

`ifndef SYNTHESIS
  // fill never exceeds the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({{(PW-CNT_W){1'b0}}, used_q} <= DEPTH_P))
    else $error("fill count beyond store depth");

  // a result is only shown once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // an accepted item either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither running nor finished");

  // the fill count only moves together with a result
  a_fill_moves_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> done_o)
    else $error("fill count changed without a result");
`endif

endmodule

// ===== bench/tb_array_list_insert_delete_search_core.sv =====
// Self-checking bench for the array list core: drives list operations,
// predicts every result from its own copy of the list and checks each strobe.
// Depends on alid_pkg and array_list_insert_delete_search_core.
module tb_array_list_insert_delete_search_core
  import alid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_OPS = 650;
  // kinds the block treats as no-ops
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } list_op_t;

  typedef struct {
    status_e           status;
    logic [IDX_W-1:0]  position;
    logic [DATA_W-1:0] removed;
    logic [CNT_W-1:0]  fill;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind_i = '0;
  logic [IDX_W-1:0] index_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic done_o;
  logic [STAT_W-1:0] status_o;
  logic [IDX_W-1:0] position_o;
  logic signed [DATA_W-1:0] removed_value_o;
  logic [CNT_W-1:0] fill_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i = '0;

  // shadow of the list and its register
  logic [DATA_W-1:0] list_words [LIST_DEPTH];
  int unsigned list_fill = 0;
  logic [CNT_W-1:0] list_cap = CAP_RESET;

  list_op_t op_queue[$];
  list_result_t awaited_results[$];
  logic [DATA_W-1:0] word_pool [8];

  int unsigned ops_queued = 0;
  int unsigned results_seen = 0;
  int unsigned fault_count = 0;
  int unsigned search_hits = 0;
  int unsigned cap_writes = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_cycles = 0;

  array_list_insert_delete_search_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .index_i         (index_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .position_o      (position_o),
    .removed_value_o (removed_value_o),
    .fill_count_o    (fill_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // apply one operation to the shadow list and queue the result it should give
  task automatic apply_list_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                               input logic [DATA_W-1:0] word);
    list_result_t res;
    int unsigned room;
    int unsigned i;
    int lo;
    int hi;
    int mid;
    logic [DATA_W-1:0] tmp;
    room = (list_cap > LIST_DEPTH) ? LIST_DEPTH : list_cap;
    res.status = STAT_OK;
    res.position = '0;
    res.removed = '0;
    case (kind)
      K_APPEND: begin
        if (list_fill < room) begin
          list_words[list_fill] = word;
          list_fill++;
        end else begin
          res.status = STAT_FULL;
        end
      end
      K_INSERT: begin
        if (idx > list_fill) begin
          res.status = STAT_RANGE;
        end else if (list_fill >= room) begin
          res.status = STAT_FULL;
        end else begin
          for (i = list_fill; i > idx; i--) list_words[i] = list_words[i-1];
          list_words[idx] = word;
          list_fill++;
        end
      end
      K_DELETE: begin
        if (idx >= list_fill) begin
          res.status = STAT_RANGE;
        end else begin
          res.removed = list_words[idx];
          for (i = idx; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
          list_fill--;
        end
      end
      K_LINEAR, K_MTF: begin
        res.status = STAT_MISS;
        for (i = 0; i < list_fill; i++) begin
          if (list_words[i] == word) begin
            res.status = STAT_OK;
            res.position = i[IDX_W-1:0];
            if (kind == K_MTF) begin
              tmp = list_words[i];
              list_words[i] = list_words[0];
              list_words[0] = tmp;
            end
            break;
          end
        end
      end
      K_BINARY: begin
        // plain halving walk, signed compare, whatever the order of the list
        res.status = STAT_MISS;
        lo = 0;
        hi = int'(list_fill) - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if ($signed(word) == $signed(list_words[mid])) begin
            res.status = STAT_OK;
            res.position = mid[IDX_W-1:0];
            break;
          end else if ($signed(word) < $signed(list_words[mid])) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: begin
      end
    endcase
    if ((kind == K_LINEAR || kind == K_MTF || kind == K_BINARY) && res.status == STAT_OK)
      search_hits++;
    res.fill = list_fill[CNT_W-1:0];
    awaited_results.push_back(res);
  endtask

  // item driver: predicts on acceptance, then offers the next pending item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_list_op(kind_i, index_i, value_i);
      if (!start || !busy) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          kind_i  <= op_queue[0].kind;
          index_i <= op_queue[0].index;
          value_i <= op_queue[0].value;
          void'(op_queue.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("ERROR: result with nothing awaited:",
                   " status %0d pos %0d removed %h fill %0d",
                   status_o, position_o, removed_value_o, fill_count_o);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || position_o !== want.position ||
            removed_value_o !== want.removed || fill_count_o !== want.fill) begin
          fault_count++;
          if (fault_count <= 10)
            $display("ERROR: result %0d: expected status %0d pos %0d removed %h fill %0d,",
                     results_seen, want.status, want.position, want.removed, want.fill,
                     " got status %0d pos %0d removed %h fill %0d",
                     status_o, position_o, removed_value_o, fill_count_o);
        end
      end
    end
  end

  // cycles in which no item, result or register write moved
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
    $display("tb_array_list_insert_delete_search_core failed");
    $finish;
  end

  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] word);
    list_op_t op;
    op.kind = kind;
    op.index = idx;
    op.value = word;
    op_queue.push_back(op);
    ops_queued++;
  endtask

  // capacity write, only once every queued item has given its result
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    while (!(results_seen == ops_queued && !busy)) @(posedge clk_i);
    cfg_data_i <= cap;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    list_cap = cap;
    cap_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(9) < 7) return word_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(1) == 0) return IDX_W'($urandom_range(4));
    return IDX_W'($urandom_range(15));
  endfunction

  // empty the list, build an ascending run, then binary search it
  task automatic queue_sorted_run(inout int unsigned budget);
    logic [DATA_W-1:0] run_words [LIST_DEPTH];
    logic signed [DATA_W-1:0] w;
    int unsigned n;
    int unsigned k;
    n = $urandom_range(1, 12);
    w = $signed($urandom()) >>> 1;
    for (k = 0; k < LIST_DEPTH; k++) queue_op(K_DELETE, '0, '0);
    for (k = 0; k < n; k++) begin
      run_words[k] = w;
      queue_op(K_APPEND, pick_index(), w);
      w = w + $urandom_range(1, 1000);
    end
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(3) == 0)
        queue_op(K_BINARY, pick_index(), run_words[$urandom_range(n - 1)] + 1);
      else
        queue_op(K_BINARY, pick_index(), run_words[$urandom_range(n - 1)]);
    end
    budget = (budget > LIST_DEPTH + n + 6) ? budget - LIST_DEPTH - n - 6 : 0;
  endtask

  task automatic queue_random_ops(input int unsigned count);
    int unsigned left;
    int unsigned r;
    int unsigned k;
    left = count;
    word_pool[0] = WORD_MIN;
    word_pool[1] = WORD_MAX;
    word_pool[2] = '0;
    word_pool[3] = '1;
    for (k = 4; k < 8; k++) word_pool[k] = $urandom();
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_sorted_run(left);
      end else begin
        if (r < 28) queue_op(K_APPEND, pick_index(), pick_word());
        else if (r < 43) queue_op(K_INSERT, pick_index(), pick_word());
        else if (r < 66) queue_op(K_DELETE, pick_index(), pick_word());
        else if (r < 79) queue_op(K_LINEAR, pick_index(), pick_word());
        else if (r < 89) queue_op(K_MTF, pick_index(), pick_word());
        else if (r < 96) queue_op(K_BINARY, pick_index(), pick_word());
        else if (r < 98) queue_op(K_SPARE_LO, pick_index(), $urandom());
        else queue_op(K_SPARE_HI, pick_index(), $urandom());
        left--;
      end
    end
  endtask

  // main sequence
  initial begin
    logic [CNT_W-1:0] cap_plan [8];
    int unsigned p;
    cap_plan = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd5, 5'd20, 5'd12, 5'd16};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, edges of every field, each operation and no-op kinds
    sender_idle_pct = 32;
    queue_op(K_LINEAR, 4'd0, 32'd5);
    queue_op(K_BINARY, 4'd0, 32'd5);
    queue_op(K_MTF, 4'd0, 32'd5);
    queue_op(K_DELETE, 4'd0, '0);
    queue_op(K_INSERT, 4'd1, 32'd9);
    queue_op(K_INSERT, 4'd0, WORD_MIN);
    queue_op(K_APPEND, 4'd15, WORD_MAX);
    queue_op(K_INSERT, 4'd1, '1);
    queue_op(K_INSERT, 4'd3, '0);
    queue_op(K_APPEND, 4'd0, 32'h5555_5555);
    queue_op(K_INSERT, 4'd15, 32'h1234_5678);
    queue_op(K_BINARY, 4'd0, '1);
    queue_op(K_LINEAR, 4'd8, WORD_MAX);
    queue_op(K_MTF, 4'd0, '0);
    queue_op(K_MTF, 4'd7, WORD_MIN);
    queue_op(K_LINEAR, 4'd0, 32'hAAAA_AAAA);
    queue_op(K_DELETE, 4'd15, '1);
    queue_op(K_DELETE, 4'd4, '0);
    queue_op(K_DELETE, 4'd0, '0);
    queue_op(K_SPARE_LO, 4'd15, '1);
    queue_op(K_SPARE_HI, 4'd0, '0);
    queue_op(K_BINARY, 4'd0, WORD_MAX);
    queue_op(K_APPEND, 4'd0, 32'hAAAA_AAAA);

    // random phases, each under its own capacity; sender idling 32, 80, then none
    for (p = 0; p < 8; p++) begin
      write_capacity(cap_plan[p]);
      sender_idle_pct = (p < 3) ? 32 : (p < 6) ? 80 : 0;
      queue_random_ops(RANDOM_OPS / 8);
    end

    while (results_seen != ops_queued) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      fault_count++;
      $display("ERROR: %0d results never arrived", awaited_results.size());
    end
    $display("Covered %0d list operations under %0d capacity writes, %0d search hits",
             ops_queued, cap_writes, search_hits);
    $display("Faults found: %0d", fault_count);
    if (fault_count == 0) begin
      $display("tb_array_list_insert_delete_search_core passed");
    end else begin
      $display("tb_array_list_insert_delete_search_core failed");
    end
    $finish;
  end

endmodule

// ===== array_list_insert_delete_search_core.f =====
rtl/alid_pkg.sv
rtl/alid_ram.sv
rtl/alid_cmp.sv
rtl/array_list_insert_delete_search_core.sv
bench/tb_array_list_insert_delete_search_core.sv
